// ===== rtl/core/pea_pkg.sv =====
// Package for the page extent allocator.
// Holds the state, phase and scan codes, status codes and register indexes.
// No dependencies.
package pea_pkg;

  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;
  localparam int ADDR_W   = 32;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NORUN   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd3;
  localparam logic [STATUS_W-1:0] ST_PASTEND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  localparam logic CFG_TOTAL_PAGES  = 1'b0;
  localparam logic CFG_BASE_ADDRESS = 1'b1;

  localparam logic TBL_FREE = 1'b0;
  localparam logic TBL_USED = 1'b1;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DIV, S_MUL, S_SCAN, S_SHIFT, S_STEP
  } state_t;

  typedef enum logic [3:0] {
    PH_A_FIT, PH_A_RM, PH_A_USED, PH_A_INS,
    PH_F_DIV1, PH_F_DIV2, PH_F_HOLD, PH_F_FREE, PH_F_USH, PH_F_FSH
  } phase_t;

  typedef enum logic [1:0] {
    SK_FIT, SK_UAFT, SK_HOLD, SK_FAFT
  } scan_kind_t;

  typedef enum logic [1:0] {
    OP_NONE, OP_REMOVE, OP_INSERT
  } shift_op_t;

endpackage

// ===== rtl/core/page_extent_allocator.sv =====
// Page extent allocator top level: first-fit allocate and coalescing free.
// Depends on pea_pkg and pea_ram (free and used extent tables).
//
// A request is taken when start is high and busy is low; its single result appears
// on status and result_address for one cycle with done high, and cannot be held off.
// Each table lives in a RAM with one read and one write port, so every scan and every
// shift moves one entry a cycle. When PAGE_BYTES is not a power of two a free first
// runs two reciprocal-multiply divisions and one multiply.
// A zero page count is answered straight from idle with status ST_ZERO.
// After reset the block writes the initial free extent before it goes idle.
module page_extent_allocator #(
  parameter int MAX_PAGES   = 1024,
  parameter int MAX_EXTENTS = 64,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               func,
  input  logic [pea_pkg::COUNT_W-1:0]        page_count,
  input  logic [pea_pkg::ADDR_W-1:0]         address,
  output logic                               done,
  output logic [pea_pkg::STATUS_W-1:0]       status,
  output logic [pea_pkg::ADDR_W-1:0]         result_address,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [pea_pkg::ADDR_W-1:0]         cfg_data
);

  localparam int PW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int LW = $clog2(MAX_PAGES + 1);
  localparam int EW = PW + LW;
  localparam int AW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int SH = $clog2(PAGE_BYTES);
  localparam bit PB_POW2 = (PAGE_BYTES & (PAGE_BYTES - 1)) == 0;
  localparam logic [31:0] PB32  = 32'(PAGE_BYTES);
  localparam logic [31:0] MP32  = 32'(MAX_PAGES);
  localparam logic [CW-1:0] MAXC = CW'(MAX_EXTENTS);
  // reciprocal of PAGE_BYTES: exact quotient of any 32-bit value when not a power of two
  localparam logic [63:0] RECIP = ((64'd1 << (32 + SH)) / 64'(PAGE_BYTES)) + 64'd1;
  localparam logic [31:0] RECIP_LO = RECIP[31:0];
  localparam logic        RECIP_HI = RECIP[32];

  pea_pkg::state_t     state, state_next;
  pea_pkg::phase_t     ph;
  pea_pkg::scan_kind_t sc_kind;
  pea_pkg::shift_op_t  f_op, f_op_c;

  logic [LW-1:0] tp;
  logic [31:0]   base;
  logic [CW-1:0] free_count, used_count;
  logic [pea_pkg::COUNT_W-1:0] cnt_r;
  logic [31:0]   page, us, ue;
  logic [PW-1:0] a_s;
  logic [CW-1:0] u_idx, f_pos;
  logic [EW-1:0] f_new;

  logic          sc_tbl, sc_rv, sc_found;
  logic [CW-1:0] sc_idx, sc_ridx, sc_hit_idx;
  logic [EW-1:0] sc_hit, sc_prev;

  logic          sh_tbl, sh_ins, sh_rv;
  logic [CW-1:0] sh_pos, sh_idx, sh_ridx;
  logic [EW-1:0] sh_new;

  logic [31:0]   dv_q;
  logic [63:0]   dv_p;
  logic          dv_n;

  logic          fw_en, uw_en;
  logic [AW-1:0] fw_addr, uw_addr, fr_addr, ur_addr;
  logic [EW-1:0] fw_data, uw_data, f_rdata, u_rdata;

  pea_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_free_ram (
    .clk(clk), .we(fw_en), .waddr(fw_addr), .wdata(fw_data),
    .raddr(fr_addr), .rdata(f_rdata)
  );

  pea_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_used_ram (
    .clk(clk), .we(uw_en), .waddr(uw_addr), .wdata(uw_data),
    .raddr(ur_addr), .rdata(u_rdata)
  );

  function automatic logic [EW-1:0] ent(input logic [31:0] s, input logic [31:0] l);
    return {s[PW-1:0], l[LW-1:0]};
  endfunction

  // datapath terms
  logic          cfg_wr;
  logic [31:0]   cfg_v32;
  logic [LW-1:0] cfg_tp;
  logic [EW-1:0] rd;
  logic [31:0]   rd_s32, rd_l32, hs32, hl32, ps32, pl32, cnt32, pe, hold_ue;
  logic [31:0]   page_p2;
  logic [CW-1:0] sc_cnt, sh_cnt, sh_rd_idx, sh_wr_idx, p_m1;
  logic          match, sc_issue, sc_hit_now, sc_end, sh_go, sh_end;
  logic          past_end, split, whole, mp, mn, full_f, u_need, a_ok;
  logic [65:0]   dv_sum;
  logic [31:0]   dv_quo;
  logic          done_next;

  always_comb begin
    cfg_wr   = cfg_valid && cfg_ready;
    cfg_v32  = {21'd0, cfg_data[10:0]};
    cfg_tp   = (cfg_v32 > MP32) ? LW'(MAX_PAGES) : cfg_v32[LW-1:0];
    rd       = ((state == pea_pkg::S_SHIFT) ? sh_tbl : sc_tbl) ? u_rdata : f_rdata;
    rd_s32   = 32'(rd[EW-1:LW]);
    rd_l32   = 32'(rd[LW-1:0]);
    hs32     = 32'(sc_hit[EW-1:LW]);
    hl32     = 32'(sc_hit[LW-1:0]);
    ps32     = 32'(sc_prev[EW-1:LW]);
    pl32     = 32'(sc_prev[LW-1:0]);
    cnt32    = 32'(cnt_r);
    pe       = page + cnt32;
    hold_ue  = hs32 + hl32;
    past_end = pe > hold_ue;
    page_p2  = ((address & ~(PB32 - 32'd1)) - base) >> SH;
    sc_cnt   = (sc_tbl == pea_pkg::TBL_USED) ? used_count : free_count;
    sh_cnt   = (sh_tbl == pea_pkg::TBL_USED) ? used_count : free_count;
    case (sc_kind)
      pea_pkg::SK_FIT:  match = rd_l32 >= cnt32;
      pea_pkg::SK_UAFT: match = rd_s32 > 32'(a_s);
      pea_pkg::SK_HOLD: match = (rd_s32 <= page) && (page < rd_s32 + rd_l32);
      default:          match = rd_s32 > page;
    endcase
    sc_issue   = sc_idx < sc_cnt;
    sc_hit_now = sc_rv && match;
    sc_end     = sc_hit_now || !sc_issue;
    sh_go      = sh_ins ? (sh_idx > sh_pos) : (sh_idx < sh_cnt);
    sh_end     = !sh_go && !sh_rv;
    sh_rd_idx  = sh_ins ? sh_idx - 1'b1 : sh_idx;
    sh_wr_idx  = sh_ins ? sh_ridx + 1'b1 : sh_ridx - 1'b1;
    p_m1       = sc_hit_idx - 1'b1;
    a_ok       = sc_found && (used_count < MAXC);
    split      = (page > us) && (pe < ue);
    whole      = (page == us) && (pe == ue);
    u_need     = whole || split;
    mp         = (sc_hit_idx != '0) && (ps32 + pl32 == page);
    mn         = sc_found && (pe == hs32);
    full_f     = (split && used_count >= MAXC) || (!mp && !mn && free_count >= MAXC);
    if (mp && mn) begin
      f_op_c = pea_pkg::OP_REMOVE;
    end else if (!mp && !mn) begin
      f_op_c = pea_pkg::OP_INSERT;
    end else begin
      f_op_c = pea_pkg::OP_NONE;
    end
    dv_sum    = {2'b00, dv_p} + (RECIP_HI ? {2'b00, dv_q, 32'd0} : 66'd0);
    dv_quo    = 32'(dv_sum >> (32 + SH));
    done_next = ((state == pea_pkg::S_STEP) && (state_next == pea_pkg::S_IDLE)) ||
                ((state == pea_pkg::S_IDLE) && start && (page_count == '0));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pea_pkg::S_INIT: state_next = pea_pkg::S_IDLE;
      pea_pkg::S_IDLE: begin
        if (start) begin
          if (page_count == '0) begin
            state_next = pea_pkg::S_IDLE;
          end else if (func == pea_pkg::FUNC_ALLOC || PB_POW2) begin
            state_next = pea_pkg::S_SCAN;
          end else begin
            state_next = pea_pkg::S_DIV;
          end
        end
      end
      pea_pkg::S_DIV: begin
        if (dv_n == 1'b1) begin
          state_next = (ph == pea_pkg::PH_F_DIV1) ? pea_pkg::S_MUL : pea_pkg::S_SCAN;
        end
      end
      pea_pkg::S_MUL: state_next = pea_pkg::S_DIV;
      pea_pkg::S_SCAN: if (sc_end) state_next = pea_pkg::S_STEP;
      pea_pkg::S_SHIFT: if (sh_end) state_next = pea_pkg::S_STEP;
      pea_pkg::S_STEP: begin
        unique case (ph)
          pea_pkg::PH_A_FIT: begin
            if (!a_ok) begin
              state_next = pea_pkg::S_IDLE;
            end else begin
              state_next = (hl32 == cnt32) ? pea_pkg::S_SHIFT : pea_pkg::S_SCAN;
            end
          end
          pea_pkg::PH_A_RM:   state_next = pea_pkg::S_SCAN;
          pea_pkg::PH_A_USED: state_next = pea_pkg::S_SHIFT;
          pea_pkg::PH_F_HOLD: begin
            state_next = (!sc_found || past_end) ? pea_pkg::S_IDLE : pea_pkg::S_SCAN;
          end
          pea_pkg::PH_F_FREE: begin
            if (!full_f && (u_need || f_op_c != pea_pkg::OP_NONE)) begin
              state_next = pea_pkg::S_SHIFT;
            end else begin
              state_next = pea_pkg::S_IDLE;
            end
          end
          pea_pkg::PH_F_USH: begin
            state_next = (f_op != pea_pkg::OP_NONE) ? pea_pkg::S_SHIFT : pea_pkg::S_IDLE;
          end
          default: state_next = pea_pkg::S_IDLE;
        endcase
      end
      default: state_next = pea_pkg::S_IDLE;
    endcase
  end

  // outputs and memory ports
  always_comb begin
    busy      = state != pea_pkg::S_IDLE;
    cfg_ready = state == pea_pkg::S_IDLE;
    fw_en = 1'b0; fw_addr = '0; fw_data = '0; fr_addr = '0;
    uw_en = 1'b0; uw_addr = '0; uw_data = '0; ur_addr = '0;
    case (state)
      pea_pkg::S_INIT: begin
        fw_en   = 1'b1;
        fw_data = ent(32'd0, 32'(tp));
      end
      pea_pkg::S_IDLE: begin
        if (cfg_wr && cfg_index == pea_pkg::CFG_TOTAL_PAGES) begin
          fw_en   = 1'b1;
          fw_data = ent(32'd0, 32'(cfg_tp));
        end
      end
      pea_pkg::S_SCAN: begin
        fr_addr = sc_idx[AW-1:0];
        ur_addr = sc_idx[AW-1:0];
      end
      pea_pkg::S_SHIFT: begin
        fr_addr = sh_rd_idx[AW-1:0];
        ur_addr = sh_rd_idx[AW-1:0];
        if (sh_rv) begin
          fw_en   = sh_tbl == pea_pkg::TBL_FREE;
          uw_en   = sh_tbl == pea_pkg::TBL_USED;
          fw_addr = sh_wr_idx[AW-1:0];
          uw_addr = sh_wr_idx[AW-1:0];
          fw_data = rd;
          uw_data = rd;
        end else if (sh_ins && sh_end) begin
          fw_en   = sh_tbl == pea_pkg::TBL_FREE;
          uw_en   = sh_tbl == pea_pkg::TBL_USED;
          fw_addr = sh_pos[AW-1:0];
          uw_addr = sh_pos[AW-1:0];
          fw_data = sh_new;
          uw_data = sh_new;
        end
      end
      pea_pkg::S_STEP: begin
        if (ph == pea_pkg::PH_A_FIT && a_ok && hl32 != cnt32) begin
          fw_en   = 1'b1;
          fw_addr = sc_hit_idx[AW-1:0];
          fw_data = ent(hs32 + cnt32, hl32 - cnt32);
        end
        if (ph == pea_pkg::PH_F_FREE && !full_f) begin
          uw_addr = u_idx[AW-1:0];
          if (page == us && !whole) begin
            uw_en   = 1'b1;
            uw_data = ent(pe, ue - pe);
          end else if (page != us) begin
            uw_en   = 1'b1;
            uw_data = ent(us, page - us);
          end
          if (mp) begin
            fw_en   = 1'b1;
            fw_addr = p_m1[AW-1:0];
            fw_data = ent(ps32, pl32 + cnt32 + (mn ? hl32 : 32'd0));
          end else if (mn) begin
            fw_en   = 1'b1;
            fw_addr = sc_hit_idx[AW-1:0];
            fw_data = ent(page, hl32 + cnt32);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pea_pkg::S_INIT;
      ph         <= pea_pkg::PH_A_FIT;
      tp         <= LW'(MAX_PAGES);
      base       <= '0;
      free_count <= CW'(1);
      used_count <= '0;
      sc_rv      <= 1'b0;
      sh_rv      <= 1'b0;
      f_op       <= pea_pkg::OP_NONE;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
      case (state)
        pea_pkg::S_IDLE: begin
          if (cfg_wr) begin
            if (cfg_index == pea_pkg::CFG_TOTAL_PAGES) begin
              tp         <= cfg_tp;
              free_count <= (cfg_tp == '0) ? CW'(0) : CW'(1);
              used_count <= '0;
            end else begin
              base <= cfg_data;
            end
          end
          if (start) begin
            cnt_r  <= page_count;
            sc_idx <= '0;
            sc_rv  <= 1'b0;
            if (page_count == '0) begin
              status         <= pea_pkg::ST_ZERO;
              result_address <= '0;
            end else if (func == pea_pkg::FUNC_ALLOC) begin
              ph      <= pea_pkg::PH_A_FIT;
              sc_tbl  <= pea_pkg::TBL_FREE;
              sc_kind <= pea_pkg::SK_FIT;
            end else if (PB_POW2) begin
              page    <= page_p2;
              ph      <= pea_pkg::PH_F_HOLD;
              sc_tbl  <= pea_pkg::TBL_USED;
              sc_kind <= pea_pkg::SK_HOLD;
            end else begin
              ph   <= pea_pkg::PH_F_DIV1;
              dv_q <= address;
              dv_n <= 1'b0;
            end
          end
        end
        pea_pkg::S_DIV: begin
          dv_n <= !dv_n;
          if (dv_n == 1'b0) begin
            dv_p <= {32'd0, dv_q} * {32'd0, RECIP_LO};
          end else begin
            dv_q <= dv_quo;
            if (ph == pea_pkg::PH_F_DIV2) begin
              page    <= dv_quo;
              ph      <= pea_pkg::PH_F_HOLD;
              sc_tbl  <= pea_pkg::TBL_USED;
              sc_kind <= pea_pkg::SK_HOLD;
              sc_idx  <= '0;
              sc_rv   <= 1'b0;
            end
          end
        end
        pea_pkg::S_MUL: begin
          dv_q <= dv_q * PB32 - base;
          dv_n <= 1'b0;
          ph   <= pea_pkg::PH_F_DIV2;
        end
        pea_pkg::S_SCAN: begin
          if (sc_issue) begin
            sc_idx  <= sc_idx + 1'b1;
            sc_ridx <= sc_idx;
          end
          sc_rv <= sc_issue && !sc_end;
          if (sc_rv && !match) begin
            sc_prev <= rd;
          end
          if (sc_end) begin
            sc_found   <= sc_hit_now;
            sc_hit_idx <= sc_hit_now ? sc_ridx : sc_cnt;
            sc_hit     <= rd;
          end
        end
        pea_pkg::S_SHIFT: begin
          if (sh_go) begin
            sh_idx  <= sh_ins ? sh_idx - 1'b1 : sh_idx + 1'b1;
            sh_rv   <= 1'b1;
            sh_ridx <= sh_rd_idx;
          end else begin
            sh_rv <= 1'b0;
          end
          if (sh_end) begin
            if (sh_tbl == pea_pkg::TBL_USED) begin
              used_count <= sh_ins ? used_count + 1'b1 : used_count - 1'b1;
            end else begin
              free_count <= sh_ins ? free_count + 1'b1 : free_count - 1'b1;
            end
          end
        end
        pea_pkg::S_STEP: begin
          sc_idx <= '0;
          sc_rv  <= 1'b0;
          sh_rv  <= 1'b0;
          case (ph)
            pea_pkg::PH_A_FIT: begin
              a_s <= sc_hit[EW-1:LW];
              if (!sc_found) begin
                status         <= pea_pkg::ST_NORUN;
                result_address <= '0;
              end else if (!a_ok) begin
                status         <= pea_pkg::ST_FULL;
                result_address <= '0;
              end else if (hl32 == cnt32) begin
                ph     <= pea_pkg::PH_A_RM;
                sh_tbl <= pea_pkg::TBL_FREE;
                sh_ins <= 1'b0;
                sh_pos <= sc_hit_idx;
                sh_idx <= sc_hit_idx + 1'b1;
              end else begin
                ph      <= pea_pkg::PH_A_USED;
                sc_tbl  <= pea_pkg::TBL_USED;
                sc_kind <= pea_pkg::SK_UAFT;
              end
            end
            pea_pkg::PH_A_RM: begin
              ph      <= pea_pkg::PH_A_USED;
              sc_tbl  <= pea_pkg::TBL_USED;
              sc_kind <= pea_pkg::SK_UAFT;
            end
            pea_pkg::PH_A_USED: begin
              ph     <= pea_pkg::PH_A_INS;
              sh_tbl <= pea_pkg::TBL_USED;
              sh_ins <= 1'b1;
              sh_pos <= sc_hit_idx;
              sh_idx <= used_count;
              sh_new <= ent(32'(a_s), cnt32);
            end
            pea_pkg::PH_A_INS: begin
              status         <= pea_pkg::ST_OK;
              result_address <= base + 32'(a_s) * PB32;
            end
            pea_pkg::PH_F_HOLD: begin
              if (!sc_found || past_end) begin
                status         <= sc_found ? pea_pkg::ST_PASTEND : pea_pkg::ST_UNKNOWN;
                result_address <= '0;
              end else begin
                u_idx   <= sc_hit_idx;
                us      <= hs32;
                ue      <= hold_ue;
                ph      <= pea_pkg::PH_F_FREE;
                sc_tbl  <= pea_pkg::TBL_FREE;
                sc_kind <= pea_pkg::SK_FAFT;
              end
            end
            pea_pkg::PH_F_FREE: begin
              f_op  <= f_op_c;
              f_pos <= sc_hit_idx;
              f_new <= ent(page, cnt32);
              if (full_f) begin
                status         <= pea_pkg::ST_FULL;
                result_address <= '0;
              end else if (u_need) begin
                ph     <= pea_pkg::PH_F_USH;
                sh_tbl <= pea_pkg::TBL_USED;
                sh_ins <= split;
                sh_pos <= split ? u_idx + 1'b1 : u_idx;
                sh_idx <= split ? used_count : u_idx + 1'b1;
                sh_new <= ent(pe, ue - pe);
              end else if (f_op_c != pea_pkg::OP_NONE) begin
                ph     <= pea_pkg::PH_F_FSH;
                sh_tbl <= pea_pkg::TBL_FREE;
                sh_ins <= f_op_c == pea_pkg::OP_INSERT;
                sh_pos <= sc_hit_idx;
                sh_idx <= (f_op_c == pea_pkg::OP_INSERT) ? free_count : sc_hit_idx + 1'b1;
                sh_new <= ent(page, cnt32);
              end else begin
                status         <= pea_pkg::ST_OK;
                result_address <= '0;
              end
            end
            pea_pkg::PH_F_USH: begin
              if (f_op != pea_pkg::OP_NONE) begin
                ph     <= pea_pkg::PH_F_FSH;
                sh_tbl <= pea_pkg::TBL_FREE;
                sh_ins <= f_op == pea_pkg::OP_INSERT;
                sh_pos <= f_pos;
                sh_idx <= (f_op == pea_pkg::OP_INSERT) ? free_count : f_pos + 1'b1;
                sh_new <= f_new;
              end else begin
                status         <= pea_pkg::ST_OK;
                result_address <= '0;
              end
            end
            default: begin
              status         <= pea_pkg::ST_OK;
              result_address <= '0;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (free_count <= MAXC) && (used_count <= MAXC))
    else $error("extent count beyond table depth");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (done && status != pea_pkg::ST_OK) |-> (result_address == '0))
    else $error("failed transaction returned an address");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy raised without a request");
`endif

endmodule

// ===== rtl/core/pea_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module pea_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== test/pea_checker.sv =====
// Checker for page_extent_allocator: watches the request, result and register channels,
// keeps its own copy of the extent tables and compares every result. Depends on pea_pkg.
module pea_checker #(
  parameter int MAX_PAGES   = 1024,
  parameter int MAX_EXTENTS = 64,
  parameter int PAGE_BYTES  = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          func,
  input  logic [pea_pkg::COUNT_W-1:0]   page_count,
  input  logic [pea_pkg::ADDR_W-1:0]    address,
  input  logic                          done,
  input  logic [pea_pkg::STATUS_W-1:0]  status,
  input  logic [pea_pkg::ADDR_W-1:0]    result_address,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_index,
  input  logic [pea_pkg::ADDR_W-1:0]    cfg_data,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import pea_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [ADDR_W-1:0]   addr;
  } outcome_t;

  int unsigned ext_start [2][MAX_EXTENTS];
  int unsigned ext_len   [2][MAX_EXTENTS];
  int unsigned ext_n     [2];
  int unsigned pages_managed;
  logic [31:0] page0_addr;
  outcome_t    outcomes[$];

  function automatic void tables_clear();
    for (int t = 0; t < 2; t++)
      for (int i = 0; i < MAX_EXTENTS; i++) begin
        ext_start[t][i] = 0;
        ext_len[t][i] = 0;
      end
    ext_n[TBL_USED] = 0;
    ext_n[TBL_FREE] = (pages_managed == 0) ? 0 : 1;
    ext_len[TBL_FREE][0] = pages_managed;
  endfunction

  function automatic void ext_drop(int t, int unsigned i);
    for (int unsigned j = i; j + 1 < ext_n[t]; j++) begin
      ext_start[t][j] = ext_start[t][j+1];
      ext_len[t][j] = ext_len[t][j+1];
    end
    ext_n[t]--;
  endfunction

  function automatic void ext_add(int t, int unsigned i, int unsigned s, int unsigned l);
    for (int unsigned j = ext_n[t]; j > i; j--) begin
      ext_start[t][j] = ext_start[t][j-1];
      ext_len[t][j] = ext_len[t][j-1];
    end
    ext_start[t][i] = s;
    ext_len[t][i] = l;
    ext_n[t]++;
  endfunction

  function automatic outcome_t take_pages(int unsigned cnt);
    outcome_t o;
    int unsigned i, j, s;
    o = '{st: ST_OK, addr: '0};
    for (i = 0; i < ext_n[TBL_FREE]; i++)
      if (ext_len[TBL_FREE][i] >= cnt) break;
    if (i >= ext_n[TBL_FREE]) begin
      o.st = ST_NORUN;
      return o;
    end
    if (ext_n[TBL_USED] >= MAX_EXTENTS) begin
      o.st = ST_FULL;
      return o;
    end
    s = ext_start[TBL_FREE][i];
    ext_start[TBL_FREE][i] += cnt;
    ext_len[TBL_FREE][i] -= cnt;
    if (ext_len[TBL_FREE][i] == 0) ext_drop(TBL_FREE, i);
    for (j = 0; j < ext_n[TBL_USED]; j++)
      if (ext_start[TBL_USED][j] > s) break;
    ext_add(TBL_USED, j, s, cnt);
    o.addr = page0_addr + 32'(s * PAGE_BYTES);
    return o;
  endfunction

  function automatic logic [STATUS_W-1:0] give_back(int unsigned cnt, logic [31:0] a);
    logic [31:0] aligned, pg32;
    int unsigned pg, u, p, us, ue, pe;
    bit split, mp, mn;
    aligned = a - (a % PAGE_BYTES);
    pg32 = (aligned - page0_addr) / PAGE_BYTES;
    pg = pg32;
    for (u = 0; u < ext_n[TBL_USED]; u++)
      if (ext_start[TBL_USED][u] <= pg && pg < ext_start[TBL_USED][u] + ext_len[TBL_USED][u])
        break;
    if (u >= ext_n[TBL_USED]) return ST_UNKNOWN;
    us = ext_start[TBL_USED][u];
    ue = us + ext_len[TBL_USED][u];
    pe = pg + cnt;
    if (pe > ue) return ST_PASTEND;
    split = (pg > us) && (pe < ue);
    for (p = 0; p < ext_n[TBL_FREE]; p++)
      if (ext_start[TBL_FREE][p] > pg) break;
    mp = (p > 0) && (ext_start[TBL_FREE][p-1] + ext_len[TBL_FREE][p-1] == pg);
    mn = (p < ext_n[TBL_FREE]) && (pe == ext_start[TBL_FREE][p]);
    if ((split && ext_n[TBL_USED] >= MAX_EXTENTS) ||
        (!mp && !mn && ext_n[TBL_FREE] >= MAX_EXTENTS))
      return ST_FULL;
    if (pg == us && pe == ue) begin
      ext_drop(TBL_USED, u);
    end else if (pg == us) begin
      ext_start[TBL_USED][u] = pe;
      ext_len[TBL_USED][u] = ue - pe;
    end else if (pe == ue) begin
      ext_len[TBL_USED][u] = pg - us;
    end else begin
      ext_len[TBL_USED][u] = pg - us;
      ext_add(TBL_USED, u + 1, pe, ue - pe);
    end
    if (mp && mn) begin
      ext_len[TBL_FREE][p-1] += cnt + ext_len[TBL_FREE][p];
      ext_drop(TBL_FREE, p);
    end else if (mp) begin
      ext_len[TBL_FREE][p-1] += cnt;
    end else if (mn) begin
      ext_start[TBL_FREE][p] = pg;
      ext_len[TBL_FREE][p] += cnt;
    end else begin
      ext_add(TBL_FREE, p, pg, cnt);
    end
    return ST_OK;
  endfunction

  function automatic outcome_t serve_request(logic f, int unsigned cnt, logic [31:0] a);
    outcome_t o;
    o = '{st: ST_ZERO, addr: '0};
    if (cnt == 0) return o;
    if (f == FUNC_ALLOC) return take_pages(cnt);
    o.st = give_back(cnt, a);
    return o;
  endfunction

  assign pending = outcomes.size();

  initial begin
    errors = 0;
    pages_managed = MAX_PAGES;
    page0_addr = '0;
    tables_clear();
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      pages_managed = MAX_PAGES;
      page0_addr = '0;
      tables_clear();
    end else begin
      if (done) begin
        if (outcomes.size() == 0) begin
          $display("%0t: unexpected result status=%0d addr=%h", $time, status, result_address);
          errors++;
        end else begin
          want = outcomes.pop_front();
          if (status !== want.st) begin
            $display("%0t: status expected %0d actual %0d", $time, want.st, status);
            errors++;
          end
          if (result_address !== want.addr) begin
            $display("%0t: result_address expected %h actual %h", $time, want.addr,
                     result_address);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_TOTAL_PAGES) begin
          pages_managed = (cfg_data[10:0] > MAX_PAGES) ? MAX_PAGES : cfg_data[10:0];
          tables_clear();
        end else begin
          page0_addr = cfg_data;
        end
      end
      if (start && !busy) outcomes.push_back(serve_request(func, page_count, address));
    end
  end
endmodule

// ===== test/tb_top.sv =====
// Top of the page_extent_allocator bench: clock, reset, requests and register writes.
// Depends on pea_pkg, page_extent_allocator and pea_checker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         func = pea_pkg::FUNC_ALLOC;
  logic [pea_pkg::COUNT_W-1:0]  page_count = '0;
  logic [pea_pkg::ADDR_W-1:0]   address = '0;
  logic                         done;
  logic [pea_pkg::STATUS_W-1:0] status;
  logic [pea_pkg::ADDR_W-1:0]   result_address;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic                         cfg_index = pea_pkg::CFG_TOTAL_PAGES;
  logic [pea_pkg::ADDR_W-1:0]   cfg_data = '0;
  int                           errors, pending;

  logic [31:0] held_addr[$];
  int unsigned held_cnt[$];
  bit          no_gaps;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  page_extent_allocator uut (.*);
  pea_checker chk (.*);

  task automatic pause_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    while (pending != 0) @(posedge clk);
    pause_cycles(4);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == pea_pkg::CFG_TOTAL_PAGES) begin
      held_addr.delete();
      held_cnt.delete();
    end
  endtask

  task automatic request(logic f, int unsigned cnt, logic [31:0] a);
    if (!no_gaps) pause_cycles($urandom_range(0, 19));
    start <= 1'b1;
    func <= f;
    page_count <= cnt[10:0];
    address <= a;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    do @(posedge clk); while (!done);
    if (f == pea_pkg::FUNC_ALLOC && status == pea_pkg::ST_OK && cnt != 0) begin
      held_addr.push_back(result_address);
      held_cnt.push_back(cnt);
    end
  endtask

  task automatic free_some();
    int k;
    int unsigned off, len;
    if (held_addr.size() == 0) begin
      request(pea_pkg::FUNC_FREE, $urandom_range(1, 8), $urandom);
      return;
    end
    k = $urandom_range(0, held_addr.size() - 1);
    off = $urandom_range(0, held_cnt[k] - 1);
    len = $urandom_range(1, held_cnt[k] - off);
    if ($urandom_range(0, 9) == 0) len++;
    request(pea_pkg::FUNC_FREE, len, held_addr[k] + off * 4096 + $urandom_range(0, 4095));
    if (off == 0 && len == held_cnt[k]) begin
      held_addr.delete(k);
      held_cnt.delete(k);
    end
  endtask

  task automatic random_item();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) request(pea_pkg::FUNC_ALLOC, ($urandom_range(0, 3) == 0) ?
                        $urandom_range(1, 64) : $urandom_range(1, 8), $urandom);
    else if (r < 88) free_some();
    else if (r < 92) request(1'($urandom_range(0, 1)), 0, $urandom);
    else if (r < 96) request(pea_pkg::FUNC_ALLOC, $urandom_range(0, 2047), $urandom);
    else request(pea_pkg::FUNC_FREE, $urandom_range(0, 2047), $urandom);
  endtask

  initial begin
    logic [31:0] pages_set, base_set;
    no_gaps = 1'b0;
    pause_cycles(5);
    rst <= 1'b0;

    request(pea_pkg::FUNC_ALLOC, 0, 32'hFFFF_FFFF);
    request(pea_pkg::FUNC_FREE, 0, 32'h0);
    request(pea_pkg::FUNC_ALLOC, 2047, 0);
    request(pea_pkg::FUNC_ALLOC, 1025, 0);
    request(pea_pkg::FUNC_ALLOC, 1024, 0);
    request(pea_pkg::FUNC_ALLOC, 1, 0);
    request(pea_pkg::FUNC_FREE, 1025, 32'h0);
    request(pea_pkg::FUNC_FREE, 1, 32'h0010_0000);
    request(pea_pkg::FUNC_FREE, 2, 32'h0000_5FFF);
    request(pea_pkg::FUNC_FREE, 1, 32'h0000_3000);
    request(pea_pkg::FUNC_FREE, 1, 32'h0000_4ABC);
    request(pea_pkg::FUNC_FREE, 1024, 32'h0000_0000);
    request(pea_pkg::FUNC_FREE, 1019, 32'h0000_6000);
    request(pea_pkg::FUNC_FREE, 3, 32'h0000_0FFF);
    request(pea_pkg::FUNC_ALLOC, 1024, 0);
    write_reg(pea_pkg::CFG_BASE_ADDRESS, 32'hFFFF_F000);
    request(pea_pkg::FUNC_FREE, 1, 32'h0);
    request(pea_pkg::FUNC_FREE, 1, 32'hFFFF_FFFF);
    write_reg(pea_pkg::CFG_TOTAL_PAGES, 32'hFFFF_FFFF);
    request(pea_pkg::FUNC_ALLOC, 1, 0);
    request(pea_pkg::FUNC_ALLOC, 1, 0);
    write_reg(pea_pkg::CFG_TOTAL_PAGES, 0);
    request(pea_pkg::FUNC_ALLOC, 1, 0);
    write_reg(pea_pkg::CFG_TOTAL_PAGES, 1);
    request(pea_pkg::FUNC_ALLOC, 1, 0);
    request(pea_pkg::FUNC_FREE, 1, 32'hFFFF_F000);

    // used table fills up with single pages
    write_reg(pea_pkg::CFG_TOTAL_PAGES, 100);
    write_reg(pea_pkg::CFG_BASE_ADDRESS, 0);
    no_gaps = 1'b1;
    repeat (66) request(pea_pkg::FUNC_ALLOC, 1, 0);
    no_gaps = 1'b0;

    // splits of one big extent fill the used table and grow the free table
    write_reg(pea_pkg::CFG_TOTAL_PAGES, 300);
    request(pea_pkg::FUNC_ALLOC, 300, 0);
    for (int i = 1; i < 140; i += 2) request(pea_pkg::FUNC_FREE, 1, i * 4096);

    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 5)
        0: pages_set = 1024;
        1: pages_set = $urandom_range(1, 64);
        2: pages_set = $urandom;
        3: pages_set = 1;
        default: pages_set = $urandom_range(64, 1024);
      endcase
      case (ph % 4)
        0: base_set = 0;
        1: base_set = 32'hFFFF_FFFF;
        2: base_set = $urandom & 32'hFFFF_F000;
        default: base_set = $urandom;
      endcase
      if (ph % 2) begin
        write_reg(pea_pkg::CFG_BASE_ADDRESS, base_set);
        write_reg(pea_pkg::CFG_TOTAL_PAGES, pages_set);
      end else begin
        write_reg(pea_pkg::CFG_TOTAL_PAGES, pages_set);
        write_reg(pea_pkg::CFG_BASE_ADDRESS, base_set);
      end
      no_gaps = (ph % 3 == 0);
      repeat (40) random_item();
    end

    while (pending != 0) @(posedge clk);
    pause_cycles(20);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/core/pea_pkg.sv
rtl/core/pea_ram.sv
rtl/core/page_extent_allocator.sv
test/pea_checker.sv
test/tb_top.sv
